// File: src/stop_and_wait_sender_table_macros.svh
// Assertion macros for the stop-and-wait sender checker.
// Used by swst_chk.sv only.
`ifndef STOP_AND_WAIT_SENDER_TABLE_MACROS_SVH
`define STOP_AND_WAIT_SENDER_TABLE_MACROS_SVH

// Same-cycle implication, off while reset is low.
`define SWST_AST_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("swst assertion failed");

// Next-cycle implication, off while reset is low.
`define SWST_AST_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("swst assertion failed");

`endif

// File: src/swst_pkg.sv
// Types, codes and result helpers for the stop-and-wait sender.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package swst_pkg;

    localparam logic [15:0] HEADER_BYTES  = 16'd13;
    localparam logic [4:0]  RESULT_LIMIT  = 5'd16;
    localparam logic [15:0] TIMEOUT_RESET = 16'd5;
    localparam logic [7:0]  RETRIES_RESET = 8'd5;
    localparam int          DIV_STEPS     = 25;

    localparam logic [1:0] CFG_TIMEOUT  = 2'd0;
    localparam logic [1:0] CFG_RETRIES  = 2'd1;
    localparam logic [1:0] CFG_FILE_LEN = 2'd2;

    typedef enum logic [2:0] {
        ACT_DATA      = 3'd0,
        ACT_HANDSHAKE = 3'd1,
        ACT_TERMINATE = 3'd2,
        ACT_DROPPED   = 3'd3,
        ACT_REFUSED   = 3'd4
    } t_action;

    typedef struct packed {
        logic        kind;
        logic [31:0] peer_addr;
        logic [15:0] peer_port;
        logic        is_terminate;
        logic        is_handshake;
        logic        is_ack;
        logic [23:0] packet_index;
    } t_in_item;

    typedef struct packed {
        t_action     action;
        logic [31:0] dest_addr;
        logic [15:0] dest_port;
        logic [23:0] block_index;
        logic [23:0] block_count;
        logic [15:0] payload_length;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic        valid;
        logic [31:0] addr;
        logic [15:0] port;
        logic [15:0] packet_length;
        logic [23:0] block_count;
        logic [23:0] position;
        logic [7:0]  tries;
        logic [31:0] last_sent;
    } t_entry;

    // Lookup chain passed from cell to cell.
    typedef struct packed {
        logic match_seen;
        logic free_seen;
    } t_chain;

    function automatic t_out_item mk_result(t_action a, t_entry e);
        t_out_item r;
        r                = '0;
        r.action         = a;
        r.dest_addr      = e.addr;
        r.dest_port      = e.port;
        r.block_index    = (a == ACT_DATA) ? e.position : 24'd0;
        r.block_count    = (a == ACT_HANDSHAKE) ? e.block_count : 24'd0;
        r.payload_length = e.packet_length - HEADER_BYTES;
        return r;
    endfunction

    function automatic logic [7:0] tries_inc(logic [7:0] t);
        return (t == 8'hFF) ? t : t + 8'd1;
    endfunction

endpackage

// File: src/swst_cell.sv
// One peer-table entry: holds the entry and takes part in the lookup chain.
// Depends on swst_pkg.
`timescale 1ns / 1ps

module swst_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_en,
    input  swst_pkg::t_entry  i_wr_entry,
    input  logic [31:0]       i_addr,
    input  logic [15:0]       i_port,
    input  swst_pkg::t_chain  i_chain,
    output swst_pkg::t_chain  o_chain,
    output swst_pkg::t_entry  o_entry,
    output logic              o_first_match,
    output logic              o_first_free
);
    import swst_pkg::*;

    logic   r_valid;
    t_entry r_entry;
    logic   w_match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_wr_en) begin
            r_valid <= i_wr_entry.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_entry <= i_wr_entry;
        end
    end

    assign w_match = r_valid && (r_entry.addr == i_addr) && (r_entry.port == i_port);

    always_comb begin
        o_entry            = r_entry;
        o_entry.valid      = r_valid;
        o_first_match      = w_match && !i_chain.match_seen;
        o_first_free       = !r_valid && !i_chain.free_seen;
        o_chain.match_seen = i_chain.match_seen | w_match;
        o_chain.free_seen  = i_chain.free_seen | !r_valid;
    end

endmodule

// File: src/swst_div.sv
// Restoring divider, one quotient bit per cycle, for the block count.
// Depends on swst_pkg.
`timescale 1ns / 1ps

module swst_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [24:0] i_num,
    input  logic [15:0] i_den,
    output logic        o_done,
    output logic [23:0] o_quot
);
    import swst_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [24:0] r_q;
    logic [15:0] r_rem;
    logic [15:0] r_den;
    logic [16:0] w_trial;
    logic        w_fit;

    assign w_trial = {r_rem, r_q[24]};
    assign w_fit   = w_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'(DIV_STEPS - 1);
            end else if (r_busy) begin
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt - 5'd1;
            end
        end
    end

    // The remainder stays below the divisor, so 16 bits hold it
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_q   <= {r_q[23:0], w_fit};
            r_rem <= w_fit ? 16'(w_trial - {1'b0, r_den}) : w_trial[15:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q[23:0];

endmodule

// File: src/stop_and_wait_sender_table.sv
// Stop-and-wait sender with a peer table of MAX_CLIENTS cells.
// Known peer: look-up, entry update, flush; a refused peer goes from look-up to flush.
// New peer: look-up, then the 25-step serial divider for the block count, then open.
// Tick: the scan pointer visits one cell per cycle unless the output stalls.
// One item at a time; output stalls add cycles. Synchronous active-low reset clears
// the table's valid bits, the clock and the output valid, and loads the config defaults.
`timescale 1ns / 1ps

module stop_and_wait_sender_table #(
    parameter int MAX_CLIENTS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  swst_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output swst_pkg::t_out_item  o_out_item,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [23:0]          i_cfg_data
);
    import swst_pkg::*;

    localparam int IW = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
    localparam int PW = $clog2(MAX_CLIENTS + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_LOOK, S_DIV, S_OPEN, S_KNOWN, S_SCAN, S_FLUSH
    } t_state;

    t_state      r_state;
    t_in_item    r_in;
    logic [15:0] r_timeout;
    logic [7:0]  r_retries;
    logic [23:0] r_file_len;
    logic [31:0] r_time;
    logic [IW-1:0] r_sel;
    logic [PW-1:0] r_ptr;
    logic [4:0]  r_cnt;
    t_out_item   r_pend;
    logic        r_pend_v;
    t_out_item   r_out;
    logic        r_out_v;

    // Table cells and their lookup chain
    t_entry  w_ent   [MAX_CLIENTS];
    t_chain  w_chain [MAX_CLIENTS+1];
    logic [MAX_CLIENTS-1:0] w_first_match;
    logic [MAX_CLIENTS-1:0] w_first_free;
    logic [IW-1:0] w_match_idx;
    logic [IW-1:0] w_free_idx;
    logic [IW-1:0] w_idx;
    t_entry  w_rd;
    t_entry  w_ne;
    t_out_item w_res;
    t_out_item w_last_res;
    logic    w_emit;
    logic    w_wen;
    logic    w_send;
    logic    w_go;
    logic    w_out_free;
    logic    w_flush;
    logic    w_stale;
    logic    w_scan_end;
    logic    w_len_ok;
    logic    w_div_start;
    logic    w_div_done;
    logic [23:0] w_quot;
    logic [15:0] w_pay;

    assign w_chain[0] = '0;

    for (genvar g = 0; g < MAX_CLIENTS; g++) begin : g_cell
        swst_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_wr_en      (w_wen && w_go && (w_idx == IW'(g))),
            .i_wr_entry   (w_ne),
            .i_addr       (r_in.peer_addr),
            .i_port       (r_in.peer_port),
            .i_chain      (w_chain[g]),
            .o_chain      (w_chain[g+1]),
            .o_entry      (w_ent[g]),
            .o_first_match(w_first_match[g]),
            .o_first_free (w_first_free[g])
        );
    end

    // Encode the first hits of the chain
    always_comb begin
        w_match_idx = '0;
        w_free_idx  = '0;
        for (int i = 0; i < MAX_CLIENTS; i++) begin
            if (w_first_match[i]) w_match_idx = w_match_idx | IW'(i);
            if (w_first_free[i])  w_free_idx  = w_free_idx | IW'(i);
        end
    end

    swst_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_div_start),
        .i_num  (25'(r_file_len) + 25'(w_pay) - 25'd1),
        .i_den  (w_pay),
        .o_done (w_div_done),
        .o_quot (w_quot)
    );

    assign w_out_free = !r_out_v || !i_out_stall;
    assign w_go       = !r_pend_v || w_out_free;
    assign w_flush    = (r_state == S_FLUSH) && r_pend_v && w_out_free;
    assign w_idx      = (r_state == S_SCAN) ? r_ptr[IW-1:0] : r_sel;
    assign w_rd       = w_ent[w_idx];
    assign w_stale    = (r_time - w_rd.last_sent) > {16'd0, r_timeout};
    assign w_scan_end = (r_ptr >= PW'(MAX_CLIENTS)) || (r_cnt >= RESULT_LIMIT);
    assign w_pay      = r_in.packet_index[15:0] - HEADER_BYTES;
    assign w_len_ok   = (r_in.packet_index[23:16] == 8'd0)
                        && (r_in.packet_index[15:0] > HEADER_BYTES);
    assign w_div_start = (r_state == S_LOOK) && w_go && !w_chain[MAX_CLIENTS].match_seen
                         && w_len_ok && w_chain[MAX_CLIENTS].free_seen;

    // Final result of an item: the staged one with its last flag raised
    always_comb begin
        w_last_res      = r_pend;
        w_last_res.last = 1'b1;
    end

    // Work out the result and the entry write-back for the current step
    always_comb begin
        w_ne   = w_rd;
        w_res  = '0;
        w_emit = 1'b0;
        w_wen  = 1'b0;
        w_send = 1'b0;
        case (r_state)
            S_LOOK: begin
                if (!w_chain[MAX_CLIENTS].match_seen &&
                    !(w_len_ok && w_chain[MAX_CLIENTS].free_seen)) begin
                    w_res.action    = ACT_REFUSED;
                    w_res.dest_addr = r_in.peer_addr;
                    w_res.dest_port = r_in.peer_port;
                    w_emit          = 1'b1;
                end
            end
            S_OPEN: begin
                w_ne.valid         = 1'b1;
                w_ne.addr          = r_in.peer_addr;
                w_ne.port          = r_in.peer_port;
                w_ne.packet_length = r_in.packet_index[15:0];
                w_ne.block_count   = w_quot;
                w_ne.position      = '0;
                w_ne.tries         = '0;
                w_ne.last_sent     = r_time;
                w_wen              = 1'b1;
                w_emit             = 1'b1;
                w_res              = mk_result(ACT_HANDSHAKE, w_ne);
            end
            S_KNOWN: begin
                if (r_in.is_terminate) begin
                    w_wen      = 1'b1;
                    w_emit     = 1'b1;
                    w_res      = mk_result(ACT_TERMINATE, w_rd);
                    w_ne.valid = 1'b0;
                end else if (r_in.is_handshake) begin
                    w_wen = 1'b1;
                    if (r_in.is_ack) begin
                        w_send = 1'b1;
                    end else begin
                        w_emit         = 1'b1;
                        w_res          = mk_result(ACT_HANDSHAKE, w_rd);
                        w_ne.last_sent = r_time;
                    end
                end else if (r_in.is_ack) begin
                    w_wen = 1'b1;
                    if (r_in.packet_index < w_rd.block_count) begin
                        if (r_in.packet_index == w_rd.position) begin
                            w_ne.position = w_rd.position + 24'd1;
                            w_ne.tries    = '0;
                        end else begin
                            w_ne.position = r_in.packet_index;
                            w_ne.tries    = tries_inc(w_rd.tries);
                        end
                        w_send = 1'b1;
                    end else begin
                        w_emit     = 1'b1;
                        w_res      = mk_result(ACT_TERMINATE, w_rd);
                        w_ne.valid = 1'b0;
                    end
                end
            end
            S_SCAN: begin
                if (!w_scan_end && w_rd.valid && w_stale) begin
                    w_wen = 1'b1;
                    if (w_rd.tries < r_retries) begin
                        w_ne.tries = tries_inc(w_rd.tries);
                        w_send     = 1'b1;
                    end else begin
                        w_emit     = 1'b1;
                        w_res      = mk_result(ACT_DROPPED, w_rd);
                        w_ne.valid = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
        // Send the current block, or close when none is left
        if (w_send) begin
            w_emit = 1'b1;
            if (w_ne.position >= w_ne.block_count) begin
                w_res      = mk_result(ACT_TERMINATE, w_ne);
                w_ne.valid = 1'b0;
            end else begin
                w_res          = mk_result(ACT_DATA, w_ne);
                w_ne.last_sent = r_time;
            end
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout  <= TIMEOUT_RESET;
            r_retries  <= RETRIES_RESET;
            r_file_len <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TIMEOUT:  r_timeout  <= i_cfg_data[15:0];
                CFG_RETRIES:  r_retries  <= i_cfg_data[7:0];
                CFG_FILE_LEN: r_file_len <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Sequencer, result staging and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_time   <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
            r_sel    <= '0;
            r_ptr    <= '0;
            r_cnt    <= '0;
        end else begin
            // Advance the staged result when the next one arrives or the item ends
            if (w_emit && w_go && r_pend_v) begin
                r_out   <= r_pend;
                r_out_v <= 1'b1;
            end else if (w_flush) begin
                r_out   <= w_last_res;
                r_out_v <= 1'b1;
            end else if (r_out_v && !i_out_stall) begin
                r_out_v <= 1'b0;
            end

            // Hold each result until the next one shows whether it is the last
            if (w_emit && w_go) begin
                r_pend   <= w_res;
                r_pend_v <= 1'b1;
            end else if (w_flush) begin
                r_pend_v <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_in <= i_in_item;
                        if (!i_in_item.kind) begin
                            r_time  <= r_time + 32'd1;
                            r_ptr   <= '0;
                            r_cnt   <= '0;
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_LOOK;
                        end
                    end
                end
                S_LOOK: begin
                    if (w_go) begin
                        if (w_chain[MAX_CLIENTS].match_seen) begin
                            r_sel   <= w_match_idx;
                            r_state <= S_KNOWN;
                        end else if (w_div_start) begin
                            r_sel   <= w_free_idx;
                            r_state <= S_DIV;
                        end else begin
                            r_state <= S_FLUSH;
                        end
                    end
                end
                S_DIV: begin
                    if (w_div_done) r_state <= S_OPEN;
                end
                S_OPEN, S_KNOWN: begin
                    if (w_go) r_state <= S_FLUSH;
                end
                S_SCAN: begin
                    if (w_scan_end) begin
                        r_state <= S_FLUSH;
                    end else if (w_go) begin
                        r_ptr <= r_ptr + PW'(1);
                        if (w_emit) r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_FLUSH: begin
                    if (!r_pend_v || w_out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_v;
    assign o_out_item  = r_out;

endmodule

// File: src/swst_chk.sv
// Port-level checker for the stop-and-wait sender, bound to the top level.
// Depends on swst_pkg and stop_and_wait_sender_table_macros.svh.
`timescale 1ns / 1ps
`include "stop_and_wait_sender_table_macros.svh"

module swst_chk (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input swst_pkg::t_in_item   i_in_item,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input swst_pkg::t_out_item  o_out_item,
    input logic                 i_cfg_we,
    input logic [1:0]           i_cfg_idx,
    input logic [23:0]          i_cfg_data
);
    import swst_pkg::*;

    `SWST_AST_NXT(a_rst_quiet, i_clk, 1'b1, !i_rst_n, !o_out_valid)
    `SWST_AST_NXT(a_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_out_item))
    `SWST_AST_NOW(a_refused, i_clk, i_rst_n, o_out_valid && o_out_item.action == ACT_REFUSED,
        o_out_item.last && o_out_item.payload_length == 16'd0 && o_out_item.block_index == 24'd0)
    `SWST_AST_NOW(a_blk_zero, i_clk, i_rst_n, o_out_valid && o_out_item.action != ACT_DATA,
        o_out_item.block_index == 24'd0)

endmodule

bind stop_and_wait_sender_table swst_chk u_swst_chk (.*);
